// ----- design/tme_pkg.sv -----
// Shared types, constants, microcode table and helper functions of the tape machine unit.
`default_nettype none
package tme_pkg;

  localparam int unsigned TAPE_DEPTH_DEFAULT = 65536;
  localparam int unsigned CELL_W = 8;
  localparam int unsigned PC_W = 16;
  localparam int unsigned ARG_W = 16;
  localparam int unsigned FUNC_W = 3;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_PROGRAM_LENGTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INPUT_CONNECTED = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_CONNECTED = 2'd2;

  localparam logic [FUNC_W-1:0] FN_ADD = 3'd0;
  localparam logic [FUNC_W-1:0] FN_MOVE = 3'd1;
  localparam logic [FUNC_W-1:0] FN_JUMP = 3'd2;
  localparam logic [FUNC_W-1:0] FN_IN = 3'd3;
  localparam logic [FUNC_W-1:0] FN_OUT = 3'd4;
  localparam logic [FUNC_W-1:0] FN_CLEAR = 3'd5;
  localparam logic [FUNC_W-1:0] FN_ADDCLEAR = 3'd6;
  localparam logic [FUNC_W-1:0] FN_SCAN = 3'd7;

  localparam int unsigned STEP_W = 4;
  localparam logic [STEP_W-1:0] ST_IDLE = 4'd0;
  localparam logic [STEP_W-1:0] ST_DEC = 4'd1;
  localparam logic [STEP_W-1:0] ST_OP_BASE = 4'd2;
  localparam logic [STEP_W-1:0] ST_ADD = 4'd2;
  localparam logic [STEP_W-1:0] ST_MOVE = 4'd3;
  localparam logic [STEP_W-1:0] ST_JUMP = 4'd4;
  localparam logic [STEP_W-1:0] ST_IN = 4'd5;
  localparam logic [STEP_W-1:0] ST_OUT = 4'd6;
  localparam logic [STEP_W-1:0] ST_CLEAR = 4'd7;
  localparam logic [STEP_W-1:0] ST_AC_READ = 4'd8;
  localparam logic [STEP_W-1:0] ST_SCAN = 4'd9;
  localparam logic [STEP_W-1:0] ST_AC_ADD = 4'd10;
  localparam logic [STEP_W-1:0] ST_AC_ZERO = 4'd11;
  localparam logic [STEP_W-1:0] ST_DONE = 4'd12;

  localparam logic [1:0] WD_ADD_ARG = 2'd0;
  localparam logic [1:0] WD_IN = 2'd1;
  localparam logic [1:0] WD_ZERO = 2'd2;
  localparam logic [1:0] WD_ADD_CELL = 2'd3;

  localparam logic [2:0] ACT_NONE = 3'd0;
  localparam logic [2:0] ACT_DECODE = 3'd1;
  localparam logic [2:0] ACT_MOVE = 3'd2;
  localparam logic [2:0] ACT_JUMP = 3'd3;
  localparam logic [2:0] ACT_OUT = 3'd4;
  localparam logic [2:0] ACT_SAVE = 3'd5;
  localparam logic [2:0] ACT_SCAN = 3'd6;
  localparam logic [2:0] ACT_FINISH = 3'd7;

  localparam logic [2:0] SEQ_WAIT = 3'd0;
  localparam logic [2:0] SEQ_JUMP = 3'd1;
  localparam logic [2:0] SEQ_DISPATCH = 3'd2;
  localparam logic [2:0] SEQ_SCAN = 3'd3;
  localparam logic [2:0] SEQ_FINISH = 3'd4;

  typedef struct packed {
    logic rd_tgt;
    logic wr_en;
    logic wr_tgt;
    logic [1:0] wd_sel;
    logic [2:0] act;
    logic [2:0] seq;
    logic [STEP_W-1:0] target;
  } ctrl_t;

  function automatic ctrl_t mk(input logic rd_tgt, input logic wr_en, input logic wr_tgt,
                               input logic [1:0] wd_sel, input logic [2:0] act,
                               input logic [2:0] seq, input logic [STEP_W-1:0] target);
    ctrl_t c;
    c.rd_tgt = rd_tgt;
    c.wr_en = wr_en;
    c.wr_tgt = wr_tgt;
    c.wd_sel = wd_sel;
    c.act = act;
    c.seq = seq;
    c.target = target;
    return c;
  endfunction

  function automatic ctrl_t ucode(input logic [STEP_W-1:0] step);
    ctrl_t c;
    case (step)
      ST_IDLE: c = mk(1'b0, 1'b0, 1'b0, WD_ZERO, ACT_NONE, SEQ_WAIT, ST_IDLE);
      ST_DEC: c = mk(1'b0, 1'b0, 1'b0, WD_ZERO, ACT_DECODE, SEQ_DISPATCH, ST_IDLE);
      ST_ADD: c = mk(1'b0, 1'b1, 1'b0, WD_ADD_ARG, ACT_NONE, SEQ_JUMP, ST_DONE);
      ST_MOVE: c = mk(1'b0, 1'b0, 1'b0, WD_ZERO, ACT_MOVE, SEQ_JUMP, ST_DONE);
      ST_JUMP: c = mk(1'b0, 1'b0, 1'b0, WD_ZERO, ACT_JUMP, SEQ_JUMP, ST_DONE);
      ST_IN: c = mk(1'b0, 1'b1, 1'b0, WD_IN, ACT_NONE, SEQ_JUMP, ST_DONE);
      ST_OUT: c = mk(1'b0, 1'b0, 1'b0, WD_ZERO, ACT_OUT, SEQ_JUMP, ST_DONE);
      ST_CLEAR: c = mk(1'b0, 1'b1, 1'b0, WD_ZERO, ACT_NONE, SEQ_JUMP, ST_DONE);
      ST_AC_READ: c = mk(1'b1, 1'b0, 1'b0, WD_ZERO, ACT_SAVE, SEQ_JUMP, ST_AC_ADD);
      ST_SCAN: c = mk(1'b1, 1'b0, 1'b0, WD_ZERO, ACT_SCAN, SEQ_SCAN, ST_DONE);
      ST_AC_ADD: c = mk(1'b0, 1'b1, 1'b1, WD_ADD_CELL, ACT_NONE, SEQ_JUMP, ST_AC_ZERO);
      ST_AC_ZERO: c = mk(1'b0, 1'b1, 1'b0, WD_ZERO, ACT_NONE, SEQ_JUMP, ST_DONE);
      ST_DONE: c = mk(1'b0, 1'b0, 1'b0, WD_ZERO, ACT_FINISH, SEQ_FINISH, ST_IDLE);
      default: c = mk(1'b0, 1'b0, 1'b0, WD_ZERO, ACT_NONE, SEQ_JUMP, ST_IDLE);
    endcase
    return c;
  endfunction

  // Reduces a signed operand into [0, depth) by eight compare-and-subtract steps.
  function automatic logic [15:0] tape_offset(input logic signed [ARG_W-1:0] a,
                                              input int unsigned depth);
    logic [ARG_W:0] mag;
    logic [24:0] r;
    logic [24:0] sub;
    logic [24:0] neg;
    mag = a[ARG_W-1] ? ((ARG_W+1)'(0) - {a[ARG_W-1], a}) : {1'b0, a};
    r = {8'd0, mag};
    for (int k = 7; k >= 0; k--) begin
      sub = 25'(depth) << k;
      if (r >= sub) begin
        r = r - sub;
      end
    end
    neg = 25'(depth) - r;
    if (a[ARG_W-1] && (r != 25'd0)) begin
      return neg[15:0];
    end
    return r[15:0];
  endfunction

endpackage
`default_nettype wire

// ----- design/tme_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module tme_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ----- design/tape_machine_execute_unit.sv -----
// Top level of the tape machine execute unit: microcode sequencer, datapath and tape RAM.
`default_nettype none
// After reset the unit zeroes the tape RAM, one cell per cycle, and takes no word on the
// input channel until that pass is done; configuration writes are accepted throughout. It
// then runs one instruction word at a time under a small microcode program. Most opcodes
// pass through accept, decode with the tape read, execute and result load; add-and-clear
// executes as read, add and zero steps as it reads and writes two cells through the RAM's
// one read and one write port; scan repeats its execute step once per pointer step, up to
// TAPE_DEPTH steps. A word arriving while halted goes straight to result load. The result
// register lets the next word be accepted while the previous result waits to be taken.
module tape_machine_execute_unit
  import tme_pkg::*;
#(
  parameter int unsigned TAPE_DEPTH = TAPE_DEPTH_DEFAULT
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    cfg_write,
  input  wire logic [CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [CFG_DATA_W-1:0]   cfg_data,
  input  wire logic                    in_valid,
  output logic                         in_ready,
  input  wire logic [FUNC_W-1:0]       func,
  input  wire logic signed [ARG_W-1:0] arg,
  input  wire logic [CELL_W-1:0]       in_byte,
  output logic                         res_valid,
  input  wire logic                    res_ready,
  output logic [PC_W-1:0]              next_pc,
  output logic                         halted,
  output logic                         out_valid,
  output logic [CELL_W-1:0]            out_byte
);

  localparam int unsigned AW = $clog2(TAPE_DEPTH);
  localparam int unsigned CNT_W = $clog2(TAPE_DEPTH + 1);

  logic [PC_W-1:0] program_length;
  logic input_connected;
  logic output_connected;

  logic [STEP_W-1:0] step;
  logic [STEP_W-1:0] step_next;
  ctrl_t cw;

  logic clearing;
  logic [AW-1:0] clr_addr;

  logic [AW-1:0] dp;
  logic [PC_W-1:0] pc;
  logic [PC_W-1:0] npc;
  logic [FUNC_W-1:0] func_r;
  logic signed [ARG_W-1:0] arg_r;
  logic [CELL_W-1:0] in_byte_r;
  logic [AW-1:0] off;
  logic [CELL_W-1:0] saved_cell;
  logic [CNT_W-1:0] scan_cnt;
  logic oval;
  logic [CELL_W-1:0] obyte;

  logic [AW:0] tgt_sum;
  logic [AW-1:0] tgt;
  logic [15:0] off_full;
  logic [CELL_W-1:0] rdata;
  logic [AW-1:0] raddr;
  logic ram_we;
  logic [AW-1:0] waddr;
  logic [CELL_W-1:0] wdata;
  logic cell_zero;
  logic jump_taken;
  logic accept;
  logic res_free;

  assign cw = ucode(step);
  assign in_ready = (cw.seq == SEQ_WAIT) && !clearing;
  assign accept = in_valid && in_ready;
  assign res_free = !res_valid || res_ready;
  assign cell_zero = (rdata == '0);
  assign jump_taken = (arg_r > 0) ? cell_zero : !cell_zero;

  assign off_full = tape_offset(arg_r, TAPE_DEPTH);
  assign tgt_sum = {1'b0, dp} + {1'b0, off};
  assign tgt = (tgt_sum >= (AW+1)'(TAPE_DEPTH)) ? AW'(tgt_sum - (AW+1)'(TAPE_DEPTH))
                                                 : tgt_sum[AW-1:0];

  assign raddr = cw.rd_tgt ? tgt : dp;

  always_comb begin
    case (cw.wd_sel)
      WD_ADD_ARG: wdata = rdata + arg_r[CELL_W-1:0];
      WD_IN: wdata = input_connected ? in_byte_r : '0;
      WD_ADD_CELL: wdata = rdata + saved_cell;
      default: wdata = '0;
    endcase
    if (clearing) begin
      wdata = '0;
    end
  end

  assign ram_we = clearing || cw.wr_en;
  assign waddr = clearing ? clr_addr : (cw.wr_tgt ? tgt : dp);

  tme_ram #(
    .WIDTH(CELL_W),
    .DEPTH(TAPE_DEPTH)
  ) u_tape (
    .clk(clk),
    .we(ram_we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(raddr),
    .rdata(rdata)
  );

  always_comb begin
    step_next = step;
    case (cw.seq)
      SEQ_WAIT: begin
        if (accept) begin
          step_next = (pc >= program_length) ? ST_DONE : ST_DEC;
        end
      end
      SEQ_JUMP: step_next = cw.target;
      SEQ_DISPATCH: step_next = ST_OP_BASE + STEP_W'(func_r);
      SEQ_SCAN: begin
        if (cell_zero || (scan_cnt == CNT_W'(TAPE_DEPTH))) begin
          step_next = cw.target;
        end
      end
      SEQ_FINISH: begin
        if (res_free) begin
          step_next = cw.target;
        end
      end
      default: step_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      program_length <= '0;
      input_connected <= 1'b1;
      output_connected <= 1'b1;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_PROGRAM_LENGTH: program_length <= cfg_data[PC_W-1:0];
        REG_INPUT_CONNECTED: input_connected <= cfg_data[0];
        REG_OUTPUT_CONNECTED: output_connected <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      clr_addr <= clr_addr + 1'b1;
      if (clr_addr == AW'(TAPE_DEPTH - 1)) begin
        clearing <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= ST_IDLE;
      dp <= '0;
      pc <= '0;
      res_valid <= 1'b0;
    end else begin
      step <= step_next;
      if (res_valid && res_ready && (cw.act != ACT_FINISH)) begin
        res_valid <= 1'b0;
      end
      case (cw.act)
        ACT_MOVE: dp <= tgt;
        ACT_SCAN: begin
          if (!cell_zero && (scan_cnt != CNT_W'(TAPE_DEPTH))) begin
            dp <= tgt;
          end
        end
        ACT_FINISH: begin
          if (res_free) begin
            pc <= npc;
            res_valid <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      func_r <= func;
      arg_r <= arg;
      in_byte_r <= in_byte;
      npc <= pc;
      oval <= 1'b0;
      obyte <= '0;
    end
    case (cw.act)
      ACT_DECODE: begin
        off <= off_full[AW-1:0];
        npc <= pc + 1'b1;
        scan_cnt <= '0;
      end
      ACT_JUMP: begin
        if (jump_taken) begin
          npc <= pc + arg_r;
        end
      end
      ACT_OUT: begin
        if (output_connected) begin
          oval <= 1'b1;
          obyte <= rdata;
        end
      end
      ACT_SAVE: saved_cell <= rdata;
      ACT_SCAN: scan_cnt <= scan_cnt + 1'b1;
      ACT_FINISH: begin
        if (res_free) begin
          next_pc <= npc;
          halted <= (npc >= program_length);
          out_valid <= oval;
          out_byte <= obyte;
        end
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire
